// File: design/complex_arithmetic_unit_top_macros.svh
// Assertion macros for the complex arithmetic unit
`ifndef COMPLEX_ARITHMETIC_UNIT_TOP_MACROS_SVH
`define COMPLEX_ARITHMETIC_UNIT_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define CAU_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("complex_arithmetic_unit: check failed");
// next-cycle implication
`define CAU_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("complex_arithmetic_unit: check failed");
`else
`define CAU_ASSERT_IMP(label, clk, rstn, ante, cons)
`define CAU_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif

`endif

// File: design/cau_pkg.sv
package cau_pkg;

    localparam int FRAC_BITS_DEF = 16;

    // operation codes
    typedef enum logic [1:0] {
        FUNC_ADD = 2'd0,
        FUNC_SUB = 2'd1,
        FUNC_MUL = 2'd2,
        FUNC_DIV = 2'd3
    } func_t;

    // side-band carried alongside the divider lanes
    typedef struct packed {
        logic        is_div;
        logic        dz;
        logic        neg_re;
        logic        neg_im;
        logic        ovf;
        logic [31:0] res_re;
        logic [31:0] res_im;
    } cau_side_t;

endpackage

// File: design/cau_div_pipe.sv
// Pipelined restoring divider, two lanes sharing one divisor, one quotient bit a stage
module cau_div_pipe
    import cau_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int QW = FRAC_BITS + 33
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  logic [63:0]     den_in,
    input  logic [63:0]     num_re_in,
    input  logic [63:0]     num_im_in,
    input  cau_side_t       side_in,
    output logic            out_valid,
    output logic [QW-1:0]   quo_re,
    output logic [QW-1:0]   quo_im,
    output logic            sat_re,
    output logic            sat_im,
    output cau_side_t       side_out
);

    logic [63:0]    rem_reg  [2][QW+1];
    logic [63:0]    rem_next [2][QW+1];
    logic [QW-1:0]  quo_reg  [2][QW+1];
    logic [QW-1:0]  quo_next [2][QW+1];
    logic [31:0]    nlo_reg  [2][QW+1];
    logic [31:0]    nlo_next [2][QW+1];
    logic           sat_reg  [2][QW+1];
    logic           sat_next [2][QW+1];
    logic [63:0]    den_reg  [QW+1];
    logic [63:0]    den_next [QW+1];
    cau_side_t      side_reg [QW+1];
    cau_side_t      side_next[QW+1];
    logic [QW:0]    vld_reg;
    logic [QW:0]    vld_next;
    logic [63:0]    num_in [2];

    assign num_in[0] = num_re_in;
    assign num_in[1] = num_im_in;

    // entry stage and one compare-subtract per following stage
    always_comb begin
        logic [64:0] sh;
        logic        ge;
        vld_next     = {vld_reg[QW-1:0], in_valid};
        den_next[0]  = den_in;
        side_next[0] = side_in;
        for (int l = 0; l < 2; l++) begin
            // quotient of the top half already >= 2^32: saturates
            sat_next[l][0] = {32'b0, num_in[l][63:32]} >= den_in;
            rem_next[l][0] = {32'b0, num_in[l][63:32]};
            nlo_next[l][0] = num_in[l][31:0];
            quo_next[l][0] = '0;
        end
        for (int k = 1; k <= QW; k++) begin
            den_next[k]  = den_reg[k-1];
            side_next[k] = side_reg[k-1];
            for (int l = 0; l < 2; l++) begin
                sh = {rem_reg[l][k-1], nlo_reg[l][k-1][31]};
                ge = sh >= {1'b0, den_reg[k-1]};
                rem_next[l][k] = ge ? 64'(sh - {1'b0, den_reg[k-1]}) : sh[63:0];
                quo_next[l][k] = {quo_reg[l][k-1][QW-2:0], ge};
                nlo_next[l][k] = {nlo_reg[l][k-1][30:0], 1'b0};
                sat_next[l][k] = sat_reg[l][k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            nlo_reg  <= nlo_next;
            sat_reg  <= sat_next;
            den_reg  <= den_next;
            side_reg <= side_next;
        end
    end

    assign out_valid = vld_reg[QW];
    assign quo_re    = quo_reg[0][QW];
    assign quo_im    = quo_reg[1][QW];
    assign sat_re    = sat_reg[0][QW];
    assign sat_im    = sat_reg[1][QW];
    assign side_out  = side_reg[QW];

endmodule

// File: design/complex_arithmetic_unit_top.sv
// Complex ALU: add, subtract, multiply, divide on signed fixed-point complex pairs.
// Path from input acceptance to m_tvalid: input, product, sum and sign/magnitude stages, then
// the divider pipeline of FRAC_BITS + 33 compare-subtract stages (Q16.16 by default), final and output registers.
// Throughput: one item per cycle while the skid register is empty; an output skid register keeps s_tready registered.
// Reset: synchronous, active low; clears all valid bits, output and skid flags included.
`include "complex_arithmetic_unit_top_macros.svh"
module complex_arithmetic_unit_top
    import cau_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [127:0]  s_tdata,   // a_real, a_imag, b_real, b_imag
    input  logic [1:0]    s_tuser,   // func
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [63:0]   m_tdata,   // res_real, res_imag
    output logic [1:0]    m_tuser    // div_zero, overflow
);

    localparam int QW = FRAC_BITS + 33;
    localparam logic [63:0] HALF = 64'(1) << (FRAC_BITS - 1);
    localparam logic [63:0] TWO32 = 64'(1) << 32;

    // clamp sign/magnitude to 32-bit two's complement; bit 32 is overflow
    function automatic logic [32:0] sat_mag(input logic neg, input logic [63:0] mag);
        logic [32:0] r;
        if (neg) begin
            if (mag > 64'h8000_0000) r = {1'b1, 32'h8000_0000};
            else                     r = {1'b0, 32'(~mag[31:0] + 32'd1)};
        end else begin
            if (mag > 64'h7FFF_FFFF) r = {1'b1, 32'h7FFF_FFFF};
            else                     r = {1'b0, mag[31:0]};
        end
        return r;
    endfunction

    // clamp a 33-bit signed sum
    function automatic logic [32:0] sat_s33(input logic [32:0] s);
        logic [32:0] r;
        if (s[32] != s[31]) r = {1'b1, s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF};
        else                r = {1'b0, s[31:0]};
        return r;
    endfunction

    logic en;
    logic skid_valid_reg;
    assign en       = !skid_valid_reg;
    assign s_tready = en;

    // stage 0: input register
    logic               v0_reg;
    func_t              func0_reg;
    logic signed [31:0] ar0_reg, ai0_reg, br0_reg, bi0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) v0_reg <= 1'b0;
        else if (en)  v0_reg <= s_tvalid;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            func0_reg <= func_t'(s_tuser);
            ar0_reg   <= s_tdata[31:0];
            ai0_reg   <= s_tdata[63:32];
            br0_reg   <= s_tdata[95:64];
            bi0_reg   <= s_tdata[127:96];
        end
    end

    // stage 1: products, add/subtract result, zero-divisor check
    logic               v1_reg;
    func_t              func1_reg;
    logic               dz1_reg;
    logic [32:0]        asr_re1_reg, asr_im1_reg;
    logic signed [63:0] prr1_reg, pii1_reg, pri1_reg, pir1_reg, pbr1_reg, pbi1_reg;
    logic signed [32:0] as_re, as_im;

    always_comb begin
        if (func0_reg == FUNC_SUB) begin
            as_re = 33'(ar0_reg) - 33'(br0_reg);
            as_im = 33'(ai0_reg) - 33'(bi0_reg);
        end else begin
            as_re = 33'(ar0_reg) + 33'(br0_reg);
            as_im = 33'(ai0_reg) + 33'(bi0_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) v1_reg <= 1'b0;
        else if (en)  v1_reg <= v0_reg;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            func1_reg   <= func0_reg;
            dz1_reg     <= (br0_reg == 32'sd0) && (bi0_reg == 32'sd0);
            asr_re1_reg <= sat_s33(as_re);
            asr_im1_reg <= sat_s33(as_im);
            prr1_reg    <= 64'(ar0_reg) * 64'(br0_reg);
            pii1_reg    <= 64'(ai0_reg) * 64'(bi0_reg);
            pri1_reg    <= 64'(ar0_reg) * 64'(bi0_reg);
            pir1_reg    <= 64'(ai0_reg) * 64'(br0_reg);
            pbr1_reg    <= 64'(br0_reg) * 64'(br0_reg);
            pbi1_reg    <= 64'(bi0_reg) * 64'(bi0_reg);
        end
    end

    // stage 2: exact 65-bit sums and squared magnitude
    logic               v2_reg;
    func_t              func2_reg;
    logic               dz2_reg;
    logic [32:0]        asr_re2_reg, asr_im2_reg;
    logic signed [64:0] sre2_reg, sim2_reg;
    logic [63:0]        den2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) v2_reg <= 1'b0;
        else if (en)  v2_reg <= v1_reg;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            func2_reg   <= func1_reg;
            dz2_reg     <= dz1_reg;
            asr_re2_reg <= asr_re1_reg;
            asr_im2_reg <= asr_im1_reg;
            den2_reg    <= 64'(pbr1_reg) + 64'(pbi1_reg);
            if (func1_reg == FUNC_MUL) begin
                sre2_reg <= 65'(prr1_reg) - 65'(pii1_reg);
                sim2_reg <= 65'(pri1_reg) + 65'(pir1_reg);
            end else begin
                sre2_reg <= 65'(prr1_reg) + 65'(pii1_reg);
                sim2_reg <= 65'(pir1_reg) - 65'(pri1_reg);
            end
        end
    end

    // stage 3: sign and magnitude
    logic        v3_reg;
    func_t       func3_reg;
    logic        dz3_reg;
    logic [32:0] asr_re3_reg, asr_im3_reg;
    logic        nre3_reg, nim3_reg;
    logic [63:0] mre3_reg, mim3_reg, den3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) v3_reg <= 1'b0;
        else if (en)  v3_reg <= v2_reg;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            func3_reg   <= func2_reg;
            dz3_reg     <= dz2_reg;
            asr_re3_reg <= asr_re2_reg;
            asr_im3_reg <= asr_im2_reg;
            den3_reg    <= den2_reg;
            nre3_reg    <= sre2_reg[64];
            nim3_reg    <= sim2_reg[64];
            mre3_reg    <= sre2_reg[64] ? 64'(-sre2_reg) : sre2_reg[63:0];
            mim3_reg    <= sim2_reg[64] ? 64'(-sim2_reg) : sim2_reg[63:0];
        end
    end

    // multiply rounding and saturation; side-band into the divider
    cau_side_t   side3;
    logic [32:0] mul_re, mul_im;

    always_comb begin
        mul_re = sat_mag(nre3_reg, (mre3_reg + HALF) >> FRAC_BITS);
        mul_im = sat_mag(nim3_reg, (mim3_reg + HALF) >> FRAC_BITS);
        side3        = '0;
        side3.is_div = (func3_reg == FUNC_DIV);
        side3.dz     = dz3_reg;
        side3.neg_re = nre3_reg;
        side3.neg_im = nim3_reg;
        case (func3_reg)
            FUNC_MUL: begin
                side3.res_re = mul_re[31:0];
                side3.res_im = mul_im[31:0];
                side3.ovf    = mul_re[32] | mul_im[32];
            end
            FUNC_DIV: begin
                side3.res_re = '0;
                side3.res_im = '0;
                side3.ovf    = 1'b0;
            end
            default: begin
                side3.res_re = asr_re3_reg[31:0];
                side3.res_im = asr_im3_reg[31:0];
                side3.ovf    = asr_re3_reg[32] | asr_im3_reg[32];
            end
        endcase
    end

    logic          dv_valid;
    logic [QW-1:0] dq_re, dq_im;
    logic          dsat_re, dsat_im;
    cau_side_t     dside;

    cau_div_pipe #(.FRAC_BITS(FRAC_BITS)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v3_reg),
        .den_in    (den3_reg),
        .num_re_in (mre3_reg),
        .num_im_in (mim3_reg),
        .side_in   (side3),
        .out_valid (dv_valid),
        .quo_re    (dq_re),
        .quo_im    (dq_im),
        .sat_re    (dsat_re),
        .sat_im    (dsat_im),
        .side_out  (dside)
    );

    // final stage: divide rounding and result select
    logic        fin_v_reg;
    logic [31:0] fin_re_reg, fin_im_reg;
    logic        fin_dz_reg, fin_ovf_reg;
    logic [63:0] dmag_re, dmag_im;
    logic [32:0] div_re, div_im;

    always_comb begin
        dmag_re = dsat_re ? TWO32 : 64'(({1'b0, dq_re} + (QW+1)'(1)) >> 1);
        dmag_im = dsat_im ? TWO32 : 64'(({1'b0, dq_im} + (QW+1)'(1)) >> 1);
        div_re  = sat_mag(dside.neg_re, dmag_re);
        div_im  = sat_mag(dside.neg_im, dmag_im);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) fin_v_reg <= 1'b0;
        else if (en)  fin_v_reg <= dv_valid;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            if (dside.is_div && dside.dz) begin
                fin_re_reg  <= '0;
                fin_im_reg  <= '0;
                fin_dz_reg  <= 1'b1;
                fin_ovf_reg <= 1'b0;
            end else if (dside.is_div) begin
                fin_re_reg  <= div_re[31:0];
                fin_im_reg  <= div_im[31:0];
                fin_dz_reg  <= 1'b0;
                fin_ovf_reg <= div_re[32] | div_im[32];
            end else begin
                fin_re_reg  <= dside.res_re;
                fin_im_reg  <= dside.res_im;
                fin_dz_reg  <= 1'b0;
                fin_ovf_reg <= dside.ovf;
            end
        end
    end

    // output register with skid stage
    logic        m_valid_reg;
    logic [63:0] m_data_reg, skid_data_reg;
    logic [1:0]  m_user_reg, skid_user_reg;
    logic        take;

    assign take = en && fin_v_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                m_valid_reg <= take;
            end
        end else if (take) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                m_data_reg <= skid_data_reg;
                m_user_reg <= skid_user_reg;
            end else begin
                m_data_reg <= {fin_im_reg, fin_re_reg};
                m_user_reg <= {fin_ovf_reg, fin_dz_reg};
            end
        end else if (take) begin
            skid_data_reg <= {fin_im_reg, fin_re_reg};
            skid_user_reg <= {fin_ovf_reg, fin_dz_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // checks
    `CAU_ASSERT_IMP(a_skid_implies_out, aclk, aresetn, skid_valid_reg, m_valid_reg)
    `CAU_ASSERT_NXT(a_skid_drains, aclk, aresetn, skid_valid_reg && m_tready, m_valid_reg && !skid_valid_reg)
    `CAU_ASSERT_IMP(a_dz_zero, aclk, aresetn, m_valid_reg && m_user_reg[0], m_data_reg == 64'd0 && !m_user_reg[1])

endmodule
